>>> design/binary_thinning_pass_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binary thinning pass
// Concurrent checks on clk, disabled while rst_n is low; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef BINARY_THINNING_PASS_ASSERT_SVH
`define BINARY_THINNING_PASS_ASSERT_SVH
`ifndef SYNTHESIS
`define BTP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("binary_thinning_pass: assertion failed");
`define BTP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("binary_thinning_pass: assertion failed");
`else
`define BTP_ASSERT_SAME(label, ante, cons)
`define BTP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> design/btp_pkg.sv
// ----------------------------------------------------------------------------
// btp_pkg
// Shared constants, register indexes and request types of the thinning pass.
// ----------------------------------------------------------------------------
package btp_pkg;

  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int PIXEL_BITS = 8;

  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int IROW_W     = $clog2(MAX_ROWS + 2);
  localparam int OROW_W     = $clog2(MAX_ROWS);
  localparam int SIZE_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 2'd2;

  typedef enum logic [1:0] {
    DIR_NORTH = 2'd0,
    DIR_SOUTH = 2'd1,
    DIR_WEST  = 2'd2,
    DIR_EAST  = 2'd3
  } dir_t;

  typedef struct packed {
    logic                  kind;
    logic [PIXEL_BITS-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_out;
    logic                  deleted;
    logic                  last_pixel;
    logic                  frame_changed;
  } out_item_t;

  // stage 1 control: one accepted pixel on its way through the line memory
  typedef struct packed {
    logic                  valid;
    logic                  emit;
    logic                  last;
    logic                  row_first;
    logic                  row_last;
    logic                  col_first;
    logic                  col_last;
    logic [COL_W-1:0]      addr;
    logic [PIXEL_BITS-1:0] pix;
  } ctrl_t;

endpackage

>>> design/binary_thinning_pass.sv
// ----------------------------------------------------------------------------
// binary_thinning_pass
// Result: the result for pixel q comes from stream item q + frame_cols + 1
//   and passes through the stage 1 register and the output FIFO.
// Throughput: one request per clock while in_stall is low, set by
//   the line memory doing one read and one write per column per cycle.
// Reset: synchronous, active low; 64x64 frame, north, stream position zero.
//   The line memory is not cleared; stale entries never reach a result.
// ----------------------------------------------------------------------------
`include "binary_thinning_pass_assert.svh"

module binary_thinning_pass (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  btp_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output btp_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [btp_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [btp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int COL_W  = btp_pkg::COL_W;
  localparam int IROW_W = btp_pkg::IROW_W;
  localparam int OROW_W = btp_pkg::OROW_W;
  localparam int SIZE_W = btp_pkg::SIZE_W;
  localparam int PB     = btp_pkg::PIXEL_BITS;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] res;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (v > maxv) begin
      res = maxv;
    end else begin
      res = v;
    end
    return res;
  endfunction

  logic [SIZE_W-1:0]  cols_r, cols_nxt;
  logic [SIZE_W-1:0]  rows_r, rows_nxt;
  btp_pkg::dir_t      dir_r, dir_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [IROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]   ocol_r, ocol_nxt;
  logic [OROW_W-1:0]  orow_r, orow_nxt;
  logic               any_del_r, any_del_nxt;
  btp_pkg::ctrl_t     s1_r, s1_nxt;

  btp_pkg::out_item_t fifo_r [4];
  logic [1:0]         wp_r, rp_r;
  logic [2:0]         cnt_r, cnt_nxt;

  logic               cfg_hit;
  logic               acc;
  logic               skip;
  logic               go;
  logic               emit;
  logic               col_wrap;
  logic               o_col_last;
  logic               o_row_last;
  logic               s0_last;
  logic [PB-1:0]      pix_v;
  logic               res_valid;
  logic [PB-1:0]      res_pix;
  logic               res_del;
  logic               push;
  logic               pop;
  btp_pkg::out_item_t res_item;

  assign cfg_hit = cfg_we && (cfg_addr == btp_pkg::REG_FRAME_COLS ||
                              cfg_addr == btp_pkg::REG_FRAME_ROWS ||
                              cfg_addr == btp_pkg::REG_DIRECTION);

  assign in_stall   = (cnt_r + {2'b00, s1_r.valid & s1_r.emit}) >= 3'd3;
  assign acc        = in_valid && !in_stall;
  assign skip       = in_data.kind && (col_r == '0) && (row_r == '0);
  assign go         = acc && !skip;
  assign pix_v      = in_data.kind ? '0 : in_data.pixel_in;

  assign col_wrap   = (SIZE_W'(col_r) + SIZE_W'(1)) == cols_r;
  assign emit       = (row_r >= IROW_W'(2)) || (row_r == IROW_W'(1) && col_r != '0);
  assign o_col_last = (SIZE_W'(ocol_r) + SIZE_W'(1)) == cols_r;
  assign o_row_last = (SIZE_W'(orow_r) + SIZE_W'(1)) == rows_r;
  assign s0_last    = emit && o_col_last && o_row_last;

  always_comb begin
    s1_nxt           = s1_r;
    s1_nxt.valid     = go;
    s1_nxt.emit      = emit;
    s1_nxt.last      = s0_last;
    s1_nxt.row_first = (orow_r == '0);
    s1_nxt.row_last  = o_row_last;
    s1_nxt.col_first = (ocol_r == '0);
    s1_nxt.col_last  = o_col_last;
    s1_nxt.addr      = col_r;
    s1_nxt.pix       = pix_v;
  end

  always_comb begin
    cols_nxt    = cols_r;
    rows_nxt    = rows_r;
    dir_nxt     = dir_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    ocol_nxt    = ocol_r;
    orow_nxt    = orow_r;
    any_del_nxt = any_del_r;
    if (res_valid) begin
      if (s1_r.last) begin
        any_del_nxt = 1'b0;
      end else if (res_del) begin
        any_del_nxt = 1'b1;
      end
    end
    if (cfg_hit) begin
      case (cfg_addr)
        btp_pkg::REG_FRAME_COLS: cols_nxt = clamp_size(cfg_wdata, SIZE_W'(btp_pkg::MAX_COLS));
        btp_pkg::REG_FRAME_ROWS: rows_nxt = clamp_size(cfg_wdata, SIZE_W'(btp_pkg::MAX_ROWS));
        btp_pkg::REG_DIRECTION:  dir_nxt  = btp_pkg::dir_t'(cfg_wdata[1:0]);
        default: ;
      endcase
      col_nxt     = '0;
      row_nxt     = '0;
      ocol_nxt    = '0;
      orow_nxt    = '0;
      any_del_nxt = 1'b0;
    end else if (go) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_r + IROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
      if (emit) begin
        if (o_col_last) begin
          ocol_nxt = '0;
          orow_nxt = orow_r + OROW_W'(1);
        end else begin
          ocol_nxt = ocol_r + COL_W'(1);
        end
      end
      if (s0_last) begin
        col_nxt  = '0;
        row_nxt  = '0;
        ocol_nxt = '0;
        orow_nxt = '0;
      end
    end
  end

  btp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (go),
    .rd_addr   (col_r),
    .s1        (s1_r),
    .dir       (dir_r),
    .res_valid (res_valid),
    .pixel_out (res_pix),
    .deleted   (res_del)
  );

  always_comb begin
    res_item.pixel_out     = res_pix;
    res_item.deleted       = res_del;
    res_item.last_pixel    = s1_r.last;
    res_item.frame_changed = s1_r.last && (any_del_r || res_del);
  end

  assign push      = res_valid;
  assign pop       = out_valid && !out_stall;
  assign out_valid = (cnt_r != '0);
  assign out_data  = fifo_r[rp_r];
  assign cnt_nxt   = cnt_r + {2'b00, push} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r    <= SIZE_W'(64);
      rows_r    <= SIZE_W'(64);
      dir_r     <= btp_pkg::DIR_NORTH;
      col_r     <= '0;
      row_r     <= '0;
      ocol_r    <= '0;
      orow_r    <= '0;
      any_del_r <= 1'b0;
      s1_r      <= '0;
      wp_r      <= '0;
      rp_r      <= '0;
      cnt_r     <= '0;
    end else begin
      cols_r    <= cols_nxt;
      rows_r    <= rows_nxt;
      dir_r     <= dir_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      ocol_r    <= ocol_nxt;
      orow_r    <= orow_nxt;
      any_del_r <= any_del_nxt;
      s1_r      <= s1_nxt;
      cnt_r     <= cnt_nxt;
      if (push) begin
        wp_r <= wp_r + 2'd1;
      end
      if (pop) begin
        rp_r <= rp_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= res_item;
    end
  end

  `BTP_ASSERT_SAME(a_fifo_room, push, cnt_r < 3'd4)
  `BTP_ASSERT_NEXT(a_restart, go && s0_last, col_r == '0 && row_r == '0)
  `BTP_ASSERT_SAME(a_del_zero, out_valid && out_data.deleted, out_data.pixel_out == '0)
  `BTP_ASSERT_SAME(a_changed_last, out_valid && out_data.frame_changed, out_data.last_pixel)

endmodule

>>> design/btp_core.sv
// ----------------------------------------------------------------------------
// btp_core
// Line memory read-modify-write, 3x3 window and thinning decision.
// ----------------------------------------------------------------------------
module btp_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             rd_en,
  input  logic [btp_pkg::COL_W-1:0]        rd_addr,
  input  btp_pkg::ctrl_t                   s1,
  input  btp_pkg::dir_t                    dir,
  output logic                             res_valid,
  output logic [btp_pkg::PIXEL_BITS-1:0]   pixel_out,
  output logic                             deleted
);

  localparam int PB = btp_pkg::PIXEL_BITS;

  // word = {upper line, middle line}
  logic [2*PB-1:0] line_mem [btp_pkg::MAX_COLS];
  logic [2*PB-1:0] mem_q_r;
  logic [2*PB-1:0] fwd_r;
  logic            fwd_hit_r;
  logic [2*PB-1:0] rd_word;
  logic [2*PB-1:0] wr_word;
  logic [PB-1:0]   up_pix;
  logic [PB-1:0]   mid_pix;

  logic [PB-1:0]   win_r [3][3];
  logic [PB-1:0]   nwin  [3][3];
  logic [PB-1:0]   nb    [3][3];

  logic            centre_nz;
  logic            dirn_nz;
  logic [3:0]      nb_count;
  logic [2:0]      n4_count;
  logic            cand;
  logic            del;

  assign rd_word = fwd_hit_r ? fwd_r : mem_q_r;
  assign up_pix  = rd_word[2*PB-1:PB];
  assign mid_pix = rd_word[PB-1:0];
  assign wr_word = {mid_pix, s1.pix};

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r <= line_mem[rd_addr];
    end
    if (s1.valid) begin
      line_mem[s1.addr] <= wr_word;
    end
  end

  // same column read while stage 1 writes it (single column frames)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else begin
      fwd_hit_r <= rd_en && s1.valid && (s1.addr == rd_addr);
    end
    fwd_r <= wr_word;
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nwin[r][0] = win_r[r][1];
      nwin[r][1] = win_r[r][2];
    end
    nwin[0][2] = up_pix;
    nwin[1][2] = mid_pix;
    nwin[2][2] = s1.pix;
  end

  always_ff @(posedge clk) begin
    if (s1.valid) begin
      win_r <= nwin;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r == 0 && s1.row_first) || (r == 2 && s1.row_last) ||
            (c == 0 && s1.col_first) || (c == 2 && s1.col_last)) begin
          nb[r][c] = '0;
        end else begin
          nb[r][c] = nwin[r][c];
        end
      end
    end
  end

  always_comb begin
    nb_count = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!(r == 1 && c == 1)) begin
          nb_count = nb_count + 4'(nb[r][c] != '0);
        end
      end
    end
    n4_count = 3'(nb[0][1] != '0) + 3'(nb[2][1] != '0) +
               3'(nb[1][0] != '0) + 3'(nb[1][2] != '0);
  end

  always_comb begin
    case (dir)
      btp_pkg::DIR_NORTH: dirn_nz = (nb[0][1] != '0);
      btp_pkg::DIR_SOUTH: dirn_nz = (nb[2][1] != '0);
      btp_pkg::DIR_WEST:  dirn_nz = (nb[1][0] != '0);
      btp_pkg::DIR_EAST:  dirn_nz = (nb[1][2] != '0);
      default:            dirn_nz = 1'b1;
    endcase
  end

  assign centre_nz = (nb[1][1] != '0);
  assign cand      = centre_nz && !dirn_nz;
  assign del       = cand && (nb_count >= 4'd4) && (n4_count >= 3'd3);

  always_comb begin
    if (!cand) begin
      pixel_out = nb[1][1];
    end else if (del) begin
      pixel_out = '0;
    end else begin
      pixel_out = PB'(1);
    end
  end

  assign deleted   = del;
  assign res_valid = s1.valid && s1.emit;

endmodule
